### rtl/core/stw_pkg.sv
package stw_pkg;

  localparam logic [1:0] MODE_RUN   = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_PAUSE = 2'd2;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_SWITCH = 2'd1;
  localparam logic [1:0] REQ_CMD    = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_STOP   = 2'd1;
  localparam logic [1:0] CMD_HOLD   = 2'd2;
  localparam logic [1:0] CMD_RESUME = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_PAUSED  = 2'd1;
  localparam logic [1:0] ERR_STOPPED = 2'd2;

  localparam logic [1:0] LED_OFF   = 2'd0;
  localparam logic [1:0] LED_RED   = 2'd1;
  localparam logic [1:0] LED_GREEN = 2'd2;
  localparam logic [1:0] LED_BLUE  = 2'd3;

  localparam logic [1:0] REG_BLINK_WRAP    = 2'd0;
  localparam logic [1:0] REG_SWITCH_ACCEPT = 2'd1;
  localparam logic [1:0] REG_SECOND_WRAP   = 2'd2;

  localparam int unsigned CntW = 10;
  localparam int unsigned AddrW = 4;

  localparam logic [CntW-1:0] BlinkRst  = 10'd1000;
  localparam logic [CntW-1:0] AcceptRst = 10'd900;
  localparam logic [CntW-1:0] SecondRst = 10'd1000;

  localparam logic [CntW-1:0] Blink1 = 10'd250;
  localparam logic [CntW-1:0] Blink2 = 10'd500;
  localparam logic [CntW-1:0] Blink3 = 10'd750;

  localparam logic [2:0] ScanLast = 3'd4;

  localparam logic [7:0] SelPoint  = 8'h40;
  localparam logic [7:0] SelSecOne = 8'h10;
  localparam logic [7:0] SelSecTen = 8'h20;
  localparam logic [7:0] SelMinOne = 8'h40;
  localparam logic [7:0] SelMinTen = 8'h80;
  localparam logic [7:0] PatPoint  = 8'h80;

  typedef struct packed {
    logic [1:0] req_type;
    logic       sw1_pressed;
    logic       sw2_pressed;
    logic [1:0] command;
  } in_t;

  typedef struct packed {
    logic [1:0] mode_now;
    logic [1:0] led_colour;
    logic [7:0] digit_select;
    logic [7:0] segment_pattern;
    logic [1:0] error_code;
    logic [3:0] seconds_ones;
    logic [2:0] seconds_tens;
    logic [3:0] minutes_ones;
    logic [3:0] minutes_tens;
  } out_t;

  typedef struct packed {
    logic [CntW-1:0] blink_wrap;
    logic [CntW-1:0] switch_accept;
    logic [CntW-1:0] second_wrap;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [3:0]      sec_ones;
    logic [2:0]      sec_tens;
    logic [3:0]      min_ones;
    logic [3:0]      min_tens;
    logic [CntW-1:0] blink_count;
    logic [2:0]      scan_position;
    logic [CntW-1:0] second_count;
    logic [1:0]      pending;
  } state_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

### rtl/core/stw_cfg.sv
module stw_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [stw_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output stw_pkg::cfg_t             cfg_o
);

  stw_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]    idx;
  logic          wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        stw_pkg::REG_BLINK_WRAP:    cfg_d.blink_wrap    = pwdata[stw_pkg::CntW-1:0];
        stw_pkg::REG_SWITCH_ACCEPT: cfg_d.switch_accept = pwdata[stw_pkg::CntW-1:0];
        stw_pkg::REG_SECOND_WRAP:   cfg_d.second_wrap   = pwdata[stw_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      stw_pkg::REG_BLINK_WRAP:    prdata = {22'd0, cfg_q.blink_wrap};
      stw_pkg::REG_SWITCH_ACCEPT: prdata = {22'd0, cfg_q.switch_accept};
      stw_pkg::REG_SECOND_WRAP:   prdata = {22'd0, cfg_q.second_wrap};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_wrap    <= stw_pkg::BlinkRst;
      cfg_q.switch_accept <= stw_pkg::AcceptRst;
      cfg_q.second_wrap   <= stw_pkg::SecondRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/core/stw_step.sv
module stw_step (
  input  stw_pkg::cfg_t   cfg_i,
  input  stw_pkg::state_t state_i,
  input  stw_pkg::in_t    word_i,
  output stw_pkg::state_t state_o,
  output stw_pkg::out_t   word_o
);

  stw_pkg::state_t s;
  logic [1:0]      err;
  logic [1:0]      led;
  logic [7:0]      sel;
  logic [7:0]      pat;
  logic            pulse;
  logic            blink_on;
  logic            acted;

  always_comb begin
    s     = state_i;
    err   = stw_pkg::ERR_NONE;
    pulse = 1'b0;
    acted = 1'b0;

    // event of this word
    case (word_i.req_type)
      stw_pkg::REQ_TICK: begin
        s.blink_count = (s.blink_count < cfg_i.blink_wrap) ?
                        s.blink_count + 10'd1 : 10'd0;
        s.scan_position = (s.scan_position < stw_pkg::ScanLast) ?
                          s.scan_position + 3'd1 : 3'd0;
        if (s.second_count < cfg_i.second_wrap) begin
          s.second_count = s.second_count + 10'd1;
        end else begin
          s.second_count = 10'd0;
          pulse = 1'b1;
        end
      end
      stw_pkg::REQ_SWITCH: begin
        s.pending = {word_i.sw1_pressed, word_i.sw2_pressed};
      end
      stw_pkg::REQ_CMD: begin
        case (word_i.command)
          stw_pkg::CMD_START: begin
            if (s.mode == stw_pkg::MODE_PAUSE) begin
              err = stw_pkg::ERR_PAUSED;
            end else begin
              s.mode     = stw_pkg::MODE_RUN;
              s.sec_ones = 4'd0;
              s.sec_tens = 3'd0;
              s.min_ones = 4'd0;
              s.min_tens = 4'd0;
            end
          end
          stw_pkg::CMD_STOP: s.mode = stw_pkg::MODE_STOP;
          default: begin
            if (s.mode == stw_pkg::MODE_STOP) begin
              err = stw_pkg::ERR_STOPPED;
            end else begin
              s.mode = (word_i.command == stw_pkg::CMD_HOLD) ?
                       stw_pkg::MODE_PAUSE : stw_pkg::MODE_RUN;
            end
          end
        endcase
      end
      default: ;
    endcase

    blink_on = (s.blink_count <= stw_pkg::Blink1) ||
               ((s.blink_count > stw_pkg::Blink2) && (s.blink_count <= stw_pkg::Blink3));
    if (s.mode == stw_pkg::MODE_STOP) begin
      led = stw_pkg::LED_RED;
    end else if (blink_on) begin
      led = (s.mode == stw_pkg::MODE_RUN) ? stw_pkg::LED_GREEN : stw_pkg::LED_BLUE;
    end else begin
      led = stw_pkg::LED_OFF;
    end

    // display shows the time before any advance
    case (s.scan_position)
      3'd0: begin sel = stw_pkg::SelPoint;  pat = stw_pkg::PatPoint; end
      3'd1: begin sel = stw_pkg::SelSecOne; pat = stw_pkg::seg_code(s.sec_ones); end
      3'd2: begin sel = stw_pkg::SelSecTen; pat = stw_pkg::seg_code({1'b0, s.sec_tens}); end
      3'd3: begin sel = stw_pkg::SelMinOne; pat = stw_pkg::seg_code(s.min_ones); end
      3'd4: begin sel = stw_pkg::SelMinTen; pat = stw_pkg::seg_code(s.min_tens); end
      default: begin sel = 8'h00; pat = 8'h00; end
    endcase

    if ((s.mode == stw_pkg::MODE_RUN) && pulse) begin
      if (s.sec_ones == 4'd9) begin
        s.sec_ones = 4'd0;
        if (s.sec_tens == 3'd5) begin
          s.sec_tens = 3'd0;
          if (s.min_ones == 4'd9) begin
            s.min_ones = 4'd0;
            s.min_tens = (s.min_tens == 4'd9) ? 4'd0 : s.min_tens + 4'd1;
          end else begin
            s.min_ones = s.min_ones + 4'd1;
          end
        end else begin
          s.sec_tens = s.sec_tens + 3'd1;
        end
      end else begin
        s.sec_ones = s.sec_ones + 4'd1;
      end
    end

    // pending press acts only late in the blink period; bit 1 is switch one
    if (s.blink_count > cfg_i.switch_accept) begin
      if (s.mode == stw_pkg::MODE_RUN) begin
        if (s.pending[1]) begin
          s.mode = stw_pkg::MODE_STOP;
          acted  = 1'b1;
        end else if (s.pending[0]) begin
          s.mode = stw_pkg::MODE_PAUSE;
          acted  = 1'b1;
        end
      end else if (s.mode == stw_pkg::MODE_STOP) begin
        if (s.pending[1]) begin
          s.mode     = stw_pkg::MODE_RUN;
          s.sec_ones = 4'd0;
          s.sec_tens = 3'd0;
          s.min_ones = 4'd0;
          s.min_tens = 4'd0;
          acted      = 1'b1;
        end
      end else begin
        if (s.pending[1]) begin
          s.mode = stw_pkg::MODE_STOP;
          acted  = 1'b1;
        end else if (s.pending[0]) begin
          s.mode = stw_pkg::MODE_RUN;
          acted  = 1'b1;
        end
      end
      if (acted) begin
        s.pending      = 2'b00;
        s.blink_count  = 10'd0;
        s.second_count = 10'd0;
      end
    end

    state_o = s;
    word_o.mode_now        = s.mode;
    word_o.led_colour      = led;
    word_o.digit_select    = sel;
    word_o.segment_pattern = pat;
    word_o.error_code      = err;
    word_o.seconds_ones    = s.sec_ones;
    word_o.seconds_tens    = s.sec_tens;
    word_o.minutes_ones    = s.min_ones;
    word_o.minutes_tens    = s.min_tens;
  end

endmodule

### rtl/core/stopwatch_mode_and_display_scan_core.sv
// mm:ss stopwatch core with display scan and status LED. Each input word (tick,
// switch press or decoded command) yields exactly one result word. A word sits
// in an input register, goes through the combinational update logic to the
// result register; while out_ready does not stall, throughput is one word per
// cycle. Registers on the APB port: blink_wrap at 0x0, switch_accept at 0x4,
// second_wrap at 0x8.
module stopwatch_mode_and_display_scan_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  stw_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output stw_pkg::out_t             out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [stw_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  stw_pkg::cfg_t   cfg;
  stw_pkg::state_t state_q, state_nxt;
  stw_pkg::in_t    in_q;
  stw_pkg::out_t   out_q, out_nxt;
  logic            in_vld_q;
  logic            out_vld_q;
  logic            fire;

  stw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  stw_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .word_i  (in_q),
    .state_o (state_nxt),
    .word_o  (out_nxt)
  );

  // word moves to the result register when that register is free or draining
  assign fire        = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o  = ~in_vld_q | fire;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{mode: stw_pkg::MODE_STOP, default: '0};
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
        state_q   <= state_nxt;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= out_nxt;
    end
  end

endmodule

### bench/stopwatch_checker.sv
`timescale 1ns / 1ps

module stopwatch_checker
  import stw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_t              in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_t             out_data_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [31:0]      pwdata_i,
  input  logic [31:0]      prdata_i,
  input  logic             pready_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               words_o,
  output int               advances_o,
  output int               full_wraps_o,
  output int               switch_acts_o,
  output int               refusals_o
);

  logic [7:0] digit_segments [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // register copies
  logic [CntW-1:0] blink_limit;
  logic [CntW-1:0] accept_level;
  logic [CntW-1:0] second_limit;

  // watch state
  logic [1:0]      run_mode;
  logic [3:0]      sec_lo;
  logic [2:0]      sec_hi;
  logic [3:0]      min_lo;
  logic [3:0]      min_hi;
  logic [CntW-1:0] blink_cnt;
  logic [CntW-1:0] tick_cnt;
  logic [2:0]      scan_pos;
  logic [1:0]      armed_switches;

  out_t expected_readouts [$];
  out_t want;
  out_t got;
  logic [31:0] reg_value;

  function automatic string show(input out_t r);
    return $sformatf("mode=%0d led=%0d sel=%h pat=%h err=%0d time=%0d%0d:%0d%0d",
                     r.mode_now, r.led_colour, r.digit_select, r.segment_pattern,
                     r.error_code, r.minutes_tens, r.minutes_ones, r.seconds_tens,
                     r.seconds_ones);
  endfunction

  task automatic flag_mismatch(input string what, input string exp_s, input string act_s);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("[%0t] mismatch on %s", $realtime, what);
      $display("  expected %s", exp_s);
      $display("  actual   %s", act_s);
    end
  endtask

  function automatic void clear_clock();
    sec_lo = '0;
    sec_hi = '0;
    min_lo = '0;
    min_hi = '0;
  endfunction

  function automatic void bump_second();
    advances_o++;
    if (sec_lo != 4'd9) begin
      sec_lo = sec_lo + 4'd1;
    end else begin
      sec_lo = '0;
      if (sec_hi != 3'd5) begin
        sec_hi = sec_hi + 3'd1;
      end else begin
        sec_hi = '0;
        if (min_lo != 4'd9) begin
          min_lo = min_lo + 4'd1;
        end else begin
          min_lo = '0;
          if (min_hi != 4'd9) begin
            min_hi = min_hi + 4'd1;
          end else begin
            min_hi = '0;
            full_wraps_o++;
          end
        end
      end
    end
  endfunction

  // applies one word to the watch state and returns the readout it yields
  function automatic out_t next_readout(input in_t w);
    out_t r;
    logic pulse;
    logic sw_one;
    logic sw_two;
    logic acted;
    r = '0;
    pulse = 1'b0;
    acted = 1'b0;
    r.error_code = ERR_NONE;
    case (w.req_type)
      REQ_TICK: begin
        blink_cnt = (blink_cnt < blink_limit) ? blink_cnt + 1'b1 : '0;
        scan_pos = (scan_pos < ScanLast) ? scan_pos + 3'd1 : 3'd0;
        if (tick_cnt < second_limit) begin
          tick_cnt = tick_cnt + 1'b1;
        end else begin
          tick_cnt = '0;
          pulse = 1'b1;
        end
      end
      REQ_SWITCH: begin
        armed_switches = {w.sw1_pressed, w.sw2_pressed};
      end
      REQ_CMD: begin
        case (w.command)
          CMD_START: begin
            if (run_mode == MODE_PAUSE) begin
              r.error_code = ERR_PAUSED;
            end else begin
              run_mode = MODE_RUN;
              clear_clock();
            end
          end
          CMD_STOP: begin
            run_mode = MODE_STOP;
          end
          default: begin
            if (run_mode == MODE_STOP) begin
              r.error_code = ERR_STOPPED;
            end else begin
              run_mode = (w.command == CMD_HOLD) ? MODE_PAUSE : MODE_RUN;
            end
          end
        endcase
      end
      default: ;
    endcase
    if (r.error_code != ERR_NONE) refusals_o++;

    // led follows the mode before any switch takes effect
    if (run_mode == MODE_STOP) begin
      r.led_colour = LED_RED;
    end else if (blink_cnt <= Blink1 || (blink_cnt > Blink2 && blink_cnt <= Blink3)) begin
      r.led_colour = (run_mode == MODE_RUN) ? LED_GREEN : LED_BLUE;
    end else begin
      r.led_colour = LED_OFF;
    end

    // display shows the time before this word's advance
    case (scan_pos)
      3'd0: begin r.digit_select = SelPoint;  r.segment_pattern = PatPoint; end
      3'd1: begin r.digit_select = SelSecOne; r.segment_pattern = digit_segments[sec_lo]; end
      3'd2: begin
        r.digit_select = SelSecTen;
        r.segment_pattern = digit_segments[{1'b0, sec_hi}];
      end
      3'd3: begin r.digit_select = SelMinOne; r.segment_pattern = digit_segments[min_lo]; end
      3'd4: begin r.digit_select = SelMinTen; r.segment_pattern = digit_segments[min_hi]; end
      default: begin r.digit_select = '0; r.segment_pattern = '0; end
    endcase

    if (run_mode == MODE_RUN && pulse) bump_second();

    if (blink_cnt > accept_level) begin
      sw_one = armed_switches[1];
      sw_two = armed_switches[0];
      if (run_mode == MODE_RUN) begin
        if (sw_one) begin
          run_mode = MODE_STOP;
          acted = 1'b1;
        end else if (sw_two) begin
          run_mode = MODE_PAUSE;
          acted = 1'b1;
        end
      end else if (run_mode == MODE_STOP) begin
        // switch two alone stays armed while stopped
        if (sw_one) begin
          run_mode = MODE_RUN;
          clear_clock();
          acted = 1'b1;
        end
      end else begin
        if (sw_one) begin
          run_mode = MODE_STOP;
          acted = 1'b1;
        end else if (sw_two) begin
          run_mode = MODE_RUN;
          acted = 1'b1;
        end
      end
      if (acted) begin
        armed_switches = '0;
        blink_cnt = '0;
        tick_cnt = '0;
        switch_acts_o++;
      end
    end

    r.mode_now     = run_mode;
    r.seconds_ones = sec_lo;
    r.seconds_tens = sec_hi;
    r.minutes_ones = min_lo;
    r.minutes_tens = min_hi;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_limit = BlinkRst;
      accept_level = AcceptRst;
      second_limit = SecondRst;
      run_mode = MODE_STOP;
      clear_clock();
      blink_cnt = '0;
      tick_cnt = '0;
      scan_pos = '0;
      armed_switches = '0;
      expected_readouts.delete();
      fail_count_o = 0;
      pending_o = 0;
      words_o = 0;
      advances_o = 0;
      full_wraps_o = 0;
      switch_acts_o = 0;
      refusals_o = 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (paddr_i[AddrW-1:2])
            REG_BLINK_WRAP:    blink_limit = pwdata_i[CntW-1:0];
            REG_SWITCH_ACCEPT: accept_level = pwdata_i[CntW-1:0];
            REG_SECOND_WRAP:   second_limit = pwdata_i[CntW-1:0];
            default: ;
          endcase
        end else begin
          case (paddr_i[AddrW-1:2])
            REG_BLINK_WRAP:    reg_value = {22'd0, blink_limit};
            REG_SWITCH_ACCEPT: reg_value = {22'd0, accept_level};
            REG_SECOND_WRAP:   reg_value = {22'd0, second_limit};
            default:           reg_value = 32'd0;
          endcase
          if (prdata_i !== reg_value) begin
            flag_mismatch($sformatf("register read at %h", paddr_i),
                          $sformatf("%h", reg_value), $sformatf("%h", prdata_i));
          end
        end
      end

      // retire before predicting, so a same-edge word never meets its own result
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (expected_readouts.size() == 0) begin
          flag_mismatch("result word with nothing outstanding", "none", show(got));
        end else begin
          want = expected_readouts.pop_front();
          if (got.mode_now !== want.mode_now || got.led_colour !== want.led_colour ||
              got.digit_select !== want.digit_select ||
              got.segment_pattern !== want.segment_pattern ||
              got.error_code !== want.error_code ||
              got.seconds_ones !== want.seconds_ones ||
              got.seconds_tens !== want.seconds_tens ||
              got.minutes_ones !== want.minutes_ones ||
              got.minutes_tens !== want.minutes_tens) begin
            flag_mismatch("result word", show(want), show(got));
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        expected_readouts.push_back(next_readout(in_data_i));
        words_o++;
      end
      pending_o = expected_readouts.size();
    end
  end

endmodule

### bench/tb_stopwatch_mode_and_display_scan_core.sv
`timescale 1ns / 1ps

module tb_stopwatch_mode_and_display_scan_core;
  import stw_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int LongHold   = 400;
  localparam int RandomWords = 280;
  localparam int WrapTicks   = 780;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  int fail_count;
  int pending;
  int words_seen;
  int advances;
  int full_wraps;
  int switch_acts;
  int refusals;

  int cycles = 0;
  int burst_left = 0;
  int settings_used = 1;
  logic hold_armed = 1'b0;
  logic hold_done = 1'b0;

  stopwatch_mode_and_display_scan_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  stopwatch_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_i      (prdata),
    .pready_i      (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .words_o       (words_seen),
    .advances_o    (advances),
    .full_wraps_o  (full_wraps),
    .switch_acts_o (switch_acts),
    .refusals_o    (refusals)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // result side: stall pattern of its own, plus one long hold-off
  initial begin
    int pattern;
    int span;
    int held;
    @(posedge clk_i);
    forever begin
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        held = 0;
        while (held < LongHold) begin
          out_ready <= 1'b0;
          @(posedge clk_i);
          held++;
        end
      end
      pattern = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      repeat (span) begin
        case (pattern)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  function automatic in_t make_word(input logic [1:0] kind, input logic s1, input logic s2,
                                    input logic [1:0] cmd);
    in_t w;
    w.req_type = kind;
    w.sw1_pressed = s1;
    w.sw2_pressed = s2;
    w.command = cmd;
    return w;
  endfunction

  // mostly ticks, with presses and commands mixed in, and a few unused kinds
  function automatic in_t random_word();
    int pick;
    in_t w;
    pick = $urandom_range(0, 99);
    w = make_word(REQ_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  2'($urandom_range(0, 3)));
    if (pick >= 92) w.req_type = REQ_UNUSED;
    else if (pick >= 72) w.req_type = REQ_CMD;
    else if (pick >= 58) w.req_type = REQ_SWITCH;
    return w;
  endfunction

  task automatic push_word(input in_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data <= w;
    burst_left--;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [9:0] value);
    logic [31:0] noise;
    noise = $urandom();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {noise[31:10], value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [9:0] bw, input logic [9:0] sa, input logic [9:0] sw);
    drain();
    apb_access(1'b1, REG_BLINK_WRAP, bw);
    apb_access(1'b1, REG_SWITCH_ACCEPT, sa);
    apb_access(1'b1, REG_SECOND_WRAP, sw);
    apb_access(1'b0, REG_BLINK_WRAP, '0);
    apb_access(1'b0, REG_SWITCH_ACCEPT, '0);
    apb_access(1'b0, REG_SECOND_WRAP, '0);
    settings_used++;
  endtask

  task automatic push_random(input int count);
    repeat (count) push_word(random_word());
  endtask

  initial begin
    logic [9:0] bw;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values read back before any write
    apb_access(1'b0, REG_BLINK_WRAP, '0);
    apb_access(1'b0, REG_SWITCH_ACCEPT, '0);
    apb_access(1'b0, REG_SECOND_WRAP, '0);

    // mode commands in every mode, refusals, presses and the unused kind
    push_word(make_word(REQ_CMD, 1'b0, 1'b0, CMD_HOLD));
    push_word(make_word(REQ_CMD, 1'b1, 1'b1, CMD_RESUME));
    push_word(make_word(REQ_UNUSED, 1'b1, 1'b1, CMD_RESUME));
    push_word(make_word(REQ_CMD, 1'b0, 1'b0, CMD_START));
    push_word(make_word(REQ_TICK, 1'b1, 1'b0, CMD_STOP));
    push_word(make_word(REQ_CMD, 1'b0, 1'b1, CMD_HOLD));
    push_word(make_word(REQ_CMD, 1'b0, 1'b0, CMD_START));
    push_word(make_word(REQ_TICK, 1'b0, 1'b0, CMD_START));
    push_word(make_word(REQ_CMD, 1'b0, 1'b0, CMD_RESUME));
    push_word(make_word(REQ_SWITCH, 1'b1, 1'b1, CMD_START));
    push_word(make_word(REQ_CMD, 1'b0, 1'b0, CMD_STOP));
    push_word(make_word(REQ_CMD, 1'b0, 1'b0, CMD_STOP));
    push_word(make_word(REQ_CMD, 1'b0, 1'b0, CMD_START));
    push_word(make_word(REQ_SWITCH, 1'b0, 1'b1, CMD_HOLD));
    push_word(make_word(REQ_SWITCH, 1'b1, 1'b0, CMD_RESUME));
    push_word(make_word(REQ_SWITCH, 1'b0, 1'b0, CMD_STOP));
    push_word(make_word(REQ_UNUSED, 1'b0, 1'b0, CMD_START));
    repeat (5) push_word(make_word(REQ_TICK, 1'b0, 1'b0, CMD_START));
    push_word(make_word(REQ_CMD, 1'b0, 1'b0, CMD_HOLD));
    push_word(make_word(REQ_CMD, 1'b0, 1'b0, CMD_STOP));
    push_word(make_word(REQ_CMD, 1'b0, 1'b0, CMD_RESUME));

    // short wraps so presses act and seconds roll often
    reconfigure(10'd12, 10'd5, 10'd3);
    hold_armed = 1'b1;
    push_random(100);

    // wraps of 1 and the lowest threshold; counters left above the new wraps snap to zero
    reconfigure(10'd1, 10'd0, 10'd1);
    push_random(60);

    // highest values: presses never act
    reconfigure(10'd1023, 10'd1023, 10'd1023);
    push_random(40);

    repeat (4) begin
      bw = 10'($urandom_range(2, 40));
      reconfigure(bw, 10'($urandom_range(0, bw)), 10'($urandom_range(1, 12)));
      push_random((RandomWords - 200) / 4);
    end

    // long run through every led phase and several minute rollovers
    reconfigure(10'd1023, 10'd1023, 10'd1);
    push_word(make_word(REQ_CMD, 1'b0, 1'b0, CMD_START));
    repeat (WrapTicks) push_word(make_word(REQ_TICK, 1'b0, 1'b0, CMD_START));
    push_random(20);
    push_word(make_word(REQ_CMD, 1'b0, 1'b0, CMD_STOP));

    drain();
    repeat (10) @(posedge clk_i);

    $display("covered %0d words under %0d register settings, %0d refused commands",
             words_seen, settings_used, refusals);
    $display("time advanced %0d times with %0d full wraps, %0d switch actions",
             advances, full_wraps, switch_acts);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/stw_pkg.sv
rtl/core/stw_cfg.sv
rtl/core/stw_step.sv
rtl/core/stopwatch_mode_and_display_scan_core.sv
bench/stopwatch_checker.sv
bench/tb_stopwatch_mode_and_display_scan_core.sv
